@@ rtl/lfu_pkg.sv @@
// Shared types and constants for the LFU cache with LRU tie break.
package lfu_pkg;

    localparam int DEPTH       = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int CMP_W       = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] write_value;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_rsp;

    // Running result handed from cell to cell during the victim sweep.
    typedef struct packed {
        logic                   vic_found;
        logic [COUNT_WIDTH-1:0] vic_cnt;
        logic [IDX_W-1:0]       vic_rank;
        logic [IDX_W-1:0]       vic_idx;
        logic [KEY_W-1:0]       vic_key;
        logic                   free_found;
        logic [IDX_W-1:0]       free_idx;
    } t_carry;

    // Broadcast update command from the controller to every cell.
    typedef struct packed {
        logic             touch;
        logic             wr_val;
        logic [IDX_W-1:0] ref_rank;
        logic             insert;
        logic [IDX_W-1:0] ins_idx;
        logic             evict;
        logic [IDX_W-1:0] vic_idx;
        logic [IDX_W-1:0] vic_rank;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_ctrl;

endpackage

@@ rtl/lfu_cell.sv @@
// One cache entry cell: key match, update, and one stage of the victim sweep chain.
module lfu_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lfu_pkg::IDX_W-1:0]       i_idx,
    input  lfu_pkg::t_ctrl                  i_ctrl,
    input  lfu_pkg::t_carry                 i_carry,
    output lfu_pkg::t_carry                 o_carry,
    output logic                            o_hit,
    output logic [lfu_pkg::VAL_W-1:0]       o_hit_value,
    output logic [lfu_pkg::IDX_W-1:0]       o_hit_rank
);

    logic                               r_valid;
    logic [lfu_pkg::KEY_W-1:0]          r_key;
    logic [lfu_pkg::VAL_W-1:0]          r_value;
    logic [lfu_pkg::COUNT_WIDTH-1:0]    r_cnt;
    logic [lfu_pkg::IDX_W-1:0]          r_rank;
    lfu_pkg::t_carry                    r_carry;
    lfu_pkg::t_carry                    n_carry;
    logic                               take_vic;

    assign o_hit       = r_valid && (r_key == i_ctrl.key);
    assign o_hit_value = o_hit ? r_value : '0;
    assign o_hit_rank  = o_hit ? r_rank : '0;
    assign o_carry     = r_carry;

    // Lowest count wins; among equal counts the older (higher rank) wins.
    always_comb begin
        take_vic = r_valid && (!i_carry.vic_found || (r_cnt < i_carry.vic_cnt) ||
                   ((r_cnt == i_carry.vic_cnt) && (r_rank > i_carry.vic_rank)));
        n_carry = i_carry;
        if (take_vic) begin
            n_carry.vic_found = 1'b1;
            n_carry.vic_cnt   = r_cnt;
            n_carry.vic_rank  = r_rank;
            n_carry.vic_idx   = i_idx;
            n_carry.vic_key   = r_key;
        end
        if (!i_carry.free_found && !r_valid) begin
            n_carry.free_found = 1'b1;
            n_carry.free_idx   = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.touch) begin
            if (o_hit) begin
                r_rank <= '0;
                if (r_cnt != '1) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (i_ctrl.wr_val) begin
                    r_value <= i_ctrl.value;
                end
            end else if (r_valid && (r_rank < i_ctrl.ref_rank)) begin
                r_rank <= r_rank + 1'b1;
            end
        end else if (i_ctrl.insert) begin
            if (i_idx == i_ctrl.ins_idx) begin
                r_valid <= 1'b1;
                r_key   <= i_ctrl.key;
                r_value <= i_ctrl.value;
                r_cnt   <= lfu_pkg::COUNT_WIDTH'(1);
                r_rank  <= '0;
            end else if (i_ctrl.evict && (i_idx == i_ctrl.vic_idx)) begin
                r_valid <= 1'b0;
            end else if (r_valid && !(i_ctrl.evict && (r_rank > i_ctrl.vic_rank))) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

endmodule

@@ rtl/lfu_cache_lru_tiebreak_unit.sv @@
// Top level of the LFU key-value cache with LRU tie break.
//
//  channel   signals                     transfer
//  -------   -------------------------   --------------------------------------
//  command   start, i_req, busy          rising edge with start high, busy low
//  result    o_done, o_rsp               one cycle with o_done high, no stall
//  config    i_cfg_we, i_cfg_data        rising edge with i_cfg_we high
//
// A get, or a put whose key is present, goes from start through the match
// state straight to the result, and so does a get miss. A put miss runs the
// match state, a sweep down the chain of cells that finds the victim and the
// lowest free slot, then the update state; with zero capacity it ends at match.
// busy is high from the transfer until the cycle before the result; a new
// command may be taken in the cycle o_done is high. Reset is synchronous,
// active low, and clears all entries at once; the result side never stalls.
module lfu_cache_lru_tiebreak_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lfu_pkg::t_req                 i_req,
    output logic                          o_done,
    output lfu_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_SWEEP,
        S_UPDATE
    } t_state;

    t_state                         r_state;
    lfu_pkg::t_req                  r_req;
    lfu_pkg::t_rsp                  r_rsp;
    logic                           r_done;
    logic [lfu_pkg::CAP_W-1:0]      r_cap;
    logic [lfu_pkg::OCC_W-1:0]      r_occ;
    logic [lfu_pkg::IDX_W-1:0]      r_sweep_cnt;
    logic                           r_need_evict;

    lfu_pkg::t_ctrl                 ctrl;
    lfu_pkg::t_carry                carry [lfu_pkg::DEPTH+1];
    logic [lfu_pkg::DEPTH-1:0]      hit_vec;
    logic [lfu_pkg::VAL_W-1:0]      hit_value_vec [lfu_pkg::DEPTH];
    logic [lfu_pkg::IDX_W-1:0]      hit_rank_vec  [lfu_pkg::DEPTH];
    logic [lfu_pkg::VAL_W-1:0]      hit_value;
    logic [lfu_pkg::IDX_W-1:0]      hit_rank;
    logic                           any_hit;
    logic [lfu_pkg::CMP_W-1:0]      cap_eff;
    logic                           cap_zero;
    logic                           occ_full;
    lfu_pkg::t_carry                sweep_out;
    logic [lfu_pkg::IDX_W-1:0]      ins_idx;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Clamp capacity to the number of cells.
    always_comb begin
        if (lfu_pkg::CMP_W'(r_cap) > lfu_pkg::CMP_W'(lfu_pkg::DEPTH)) begin
            cap_eff = lfu_pkg::CMP_W'(lfu_pkg::DEPTH);
        end else begin
            cap_eff = lfu_pkg::CMP_W'(r_cap);
        end
        cap_zero = (cap_eff == '0);
        occ_full = (lfu_pkg::CMP_W'(r_occ) >= cap_eff);
    end

    // Fold the per-cell hit outputs; at most one cell matches.
    always_comb begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < lfu_pkg::DEPTH; i++) begin
            hit_value = hit_value | hit_value_vec[i];
            hit_rank  = hit_rank | hit_rank_vec[i];
        end
        any_hit = |hit_vec;
    end

    assign sweep_out = carry[lfu_pkg::DEPTH];

    // Insert into the lowest free cell, counting the victim's cell as free.
    always_comb begin
        if (r_need_evict) begin
            if (sweep_out.free_found && (sweep_out.free_idx < sweep_out.vic_idx)) begin
                ins_idx = sweep_out.free_idx;
            end else begin
                ins_idx = sweep_out.vic_idx;
            end
        end else begin
            ins_idx = sweep_out.free_idx;
        end
    end

    // Broadcast command to the cells.
    always_comb begin
        ctrl          = '0;
        ctrl.key      = r_req.lookup_key;
        ctrl.value    = r_req.write_value;
        ctrl.ref_rank = hit_rank;
        ctrl.ins_idx  = ins_idx;
        ctrl.vic_idx  = sweep_out.vic_idx;
        ctrl.vic_rank = sweep_out.vic_rank;
        if ((r_state == S_MATCH) && any_hit &&
            ((r_req.op == lfu_pkg::OP_GET) || !cap_zero)) begin
            ctrl.touch  = 1'b1;
            ctrl.wr_val = (r_req.op == lfu_pkg::OP_PUT);
        end
        if (r_state == S_UPDATE) begin
            ctrl.insert = 1'b1;
            ctrl.evict  = r_need_evict;
        end
    end

    assign carry[0] = '0;

    for (genvar g = 0; g < lfu_pkg::DEPTH; g++) begin : g_cell
        lfu_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_idx       (lfu_pkg::IDX_W'(g)),
            .i_ctrl      (ctrl),
            .i_carry     (carry[g]),
            .o_carry     (carry[g+1]),
            .o_hit       (hit_vec[g]),
            .o_hit_value (hit_value_vec[g]),
            .o_hit_rank  (hit_rank_vec[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cap   <= lfu_pkg::CAP_RESET;
            r_occ   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    // Latch the command on transfer.
                    r_done <= 1'b0;
                    if (start) begin
                        r_req   <= i_req;
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    // Hit value is zero when nothing matched.
                    r_rsp <= {any_hit, hit_value, 1'b0, {lfu_pkg::KEY_W{1'b0}}};
                    if (any_hit || (r_req.op == lfu_pkg::OP_GET) || cap_zero) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        // Put miss: let the chain settle over all cells.
                        r_done       <= 1'b0;
                        r_need_evict <= occ_full;
                        r_sweep_cnt  <= lfu_pkg::IDX_W'(lfu_pkg::DEPTH - 1);
                        r_state      <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    r_done <= 1'b0;
                    if (r_sweep_cnt == '0) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_sweep_cnt <= r_sweep_cnt - 1'b1;
                    end
                end
                S_UPDATE: begin
                    r_rsp.hit        <= 1'b0;
                    r_rsp.read_value <= '0;
                    r_rsp.evicted    <= r_need_evict;
                    r_rsp.evicted_key <= r_need_evict ? sweep_out.vic_key : '0;
                    if (!r_need_evict) begin
                        r_occ <= r_occ + 1'b1;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_MATCH) || ($past(r_state) == S_UPDATE))
        else $error("result strobe without a finishing state");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_rsp.hit && o_rsp.evicted))
        else $error("hit and eviction reported together");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lfu_pkg::CMP_W'(r_occ) <= lfu_pkg::CMP_W'(lfu_pkg::DEPTH))
        else $error("occupancy above depth");

    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) && r_need_evict |-> sweep_out.vic_found)
        else $error("eviction with no victim from the sweep");

    a_slot_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) && !r_need_evict |-> sweep_out.free_found)
        else $error("insert with no free cell");
`endif

endmodule

@@ test/lfu_cache_lru_tiebreak_unit_test.sv @@
// Self-checking testbench for the LFU cache with LRU tie break: shadow cache, stimulus, checks.
module lfu_cache_lru_tiebreak_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Hold the no-transfer limit well above the slowest command (a put miss,
    // with its sweep) plus the longest sender gap and drain pause.
    localparam int STALL_LIMIT = 500;
    localparam int KEY_POOL_SIZE = 32;

    // Shadow copy of the cache: predicts each result when its command is taken
    // and compares every strobed result with the oldest open prediction.
    class lfu_shadow_cache;
        logic                            slot_valid [lfu_pkg::DEPTH];
        logic [lfu_pkg::KEY_W-1:0]       slot_key   [lfu_pkg::DEPTH];
        logic [lfu_pkg::VAL_W-1:0]       slot_value [lfu_pkg::DEPTH];
        logic [lfu_pkg::COUNT_WIDTH-1:0] slot_uses  [lfu_pkg::DEPTH];
        int unsigned                     slot_age   [lfu_pkg::DEPTH]; // 0 marks the most recent
        int unsigned                     fill_level;
        logic [lfu_pkg::CAP_W-1:0]       capacity;
        lfu_pkg::t_rsp                   expected_rsp [$];
        int                              errors;

        function new();
            for (int i = 0; i < lfu_pkg::DEPTH; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_uses[i]  = '0;
                slot_age[i]   = 0;
            end
            fill_level = 0;
            capacity   = lfu_pkg::CAP_RESET;
            errors     = 0;
        endfunction

        function void set_capacity(logic [lfu_pkg::CAP_W-1:0] v);
            capacity = v;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        // Apply one command to the shadow state and queue the result it must give.
        function void note_command(lfu_pkg::t_req r);
            lfu_pkg::t_rsp e;
            int            hit_slot;
            int            victim;
            int            free_slot;
            int unsigned   room;
            int unsigned   old_age;

            e = '0;
            room = (capacity > lfu_pkg::DEPTH) ? lfu_pkg::DEPTH : capacity;
            hit_slot = -1;
            for (int i = 0; i < lfu_pkg::DEPTH; i++) begin
                if (hit_slot < 0 && slot_valid[i] && slot_key[i] == r.lookup_key) begin
                    hit_slot = i;
                end
            end

            if (hit_slot >= 0) begin
                e.hit        = 1'b1;
                e.read_value = slot_value[hit_slot];
                // A put with zero capacity reports the hit but leaves the entry alone.
                if (r.op == lfu_pkg::OP_GET || room != 0) begin
                    old_age = slot_age[hit_slot];
                    for (int i = 0; i < lfu_pkg::DEPTH; i++) begin
                        if (slot_valid[i] && slot_age[i] < old_age) begin
                            slot_age[i]++;
                        end
                    end
                    slot_age[hit_slot] = 0;
                    if (slot_uses[hit_slot] != '1) begin
                        slot_uses[hit_slot]++;
                    end
                    if (r.op == lfu_pkg::OP_PUT) begin
                        slot_value[hit_slot] = r.write_value;
                    end
                end
            end else if (r.op == lfu_pkg::OP_PUT && room != 0) begin
                // Make room first: lowest count goes, the oldest among equals.
                if (fill_level >= room) begin
                    victim = -1;
                    for (int i = 0; i < lfu_pkg::DEPTH; i++) begin
                        if (slot_valid[i] && (victim < 0 ||
                            slot_uses[i] < slot_uses[victim] ||
                            (slot_uses[i] == slot_uses[victim] &&
                             slot_age[i] > slot_age[victim]))) begin
                            victim = i;
                        end
                    end
                    if (victim >= 0) begin
                        e.evicted     = 1'b1;
                        e.evicted_key = slot_key[victim];
                        slot_valid[victim] = 1'b0;
                        for (int i = 0; i < lfu_pkg::DEPTH; i++) begin
                            if (slot_valid[i] && slot_age[i] > slot_age[victim]) begin
                                slot_age[i]--;
                            end
                        end
                        if (fill_level > 0) begin
                            fill_level--;
                        end
                    end
                end
                free_slot = -1;
                for (int i = 0; i < lfu_pkg::DEPTH; i++) begin
                    if (free_slot < 0 && !slot_valid[i]) begin
                        free_slot = i;
                    end
                end
                if (free_slot >= 0) begin
                    for (int i = 0; i < lfu_pkg::DEPTH; i++) begin
                        if (slot_valid[i]) begin
                            slot_age[i]++;
                        end
                    end
                    slot_valid[free_slot] = 1'b1;
                    slot_key[free_slot]   = r.lookup_key;
                    slot_value[free_slot] = r.write_value;
                    slot_uses[free_slot]  = lfu_pkg::COUNT_WIDTH'(1);
                    slot_age[free_slot]   = 0;
                    fill_level++;
                end
            end
            expected_rsp = {expected_rsp, e};
        endfunction

        function void check_response(lfu_pkg::t_rsp a);
            lfu_pkg::t_rsp e;
            if (expected_rsp.size() == 0) begin
                $error("result strobed with no command outstanding: %p", a);
                errors++;
                return;
            end
            e = expected_rsp[0];
            expected_rsp.delete(0);
            if (a.hit !== e.hit) begin
                $error("hit: expected %0h, actual %0h", e.hit, a.hit);
                errors++;
            end
            if (a.read_value !== e.read_value) begin
                $error("read_value: expected %0h, actual %0h", e.read_value, a.read_value);
                errors++;
            end
            if (a.evicted !== e.evicted) begin
                $error("evicted: expected %0h, actual %0h", e.evicted, a.evicted);
                errors++;
            end
            if (a.evicted_key !== e.evicted_key) begin
                $error("evicted_key: expected %0h, actual %0h", e.evicted_key, a.evicted_key);
                errors++;
            end
        endfunction
    endclass

    // Clock, reset and block inputs, all known from time zero.
    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      start      = 1'b0;
    lfu_pkg::t_req             i_req      = '0;
    logic                      i_cfg_we   = 1'b0;
    logic [lfu_pkg::CAP_W-1:0] i_cfg_data = '0;
    logic                      busy;
    logic                      o_done;
    lfu_pkg::t_rsp             o_rsp;

    lfu_shadow_cache           shadow;
    logic [lfu_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];
    bit                        idle_enable = 1'b1;
    int                        commands_sent = 0;
    int                        hits_seen = 0;
    int                        evictions_seen = 0;
    int                        capacity_writes = 0;
    int                        quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    lfu_cache_lru_tiebreak_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Result side: every strobe is a transfer, since the receiver never stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            shadow.check_response(o_rsp);
            if (o_rsp.hit) begin
                hits_seen++;
            end
            if (o_rsp.evicted) begin
                evictions_seen++;
            end
        end
    end

    // Watchdog: count cycles without any transfer and abort on a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic lfu_pkg::t_req make_req(lfu_pkg::t_op op,
                                               logic [lfu_pkg::KEY_W-1:0] k,
                                               logic [lfu_pkg::VAL_W-1:0] v);
        lfu_pkg::t_req r;
        r.op          = op;
        r.lookup_key  = k;
        r.write_value = v;
        return r;
    endfunction

    // Mostly draw from a small pool so keys repeat and hit; sometimes any key.
    function automatic logic [lfu_pkg::KEY_W-1:0] pick_key(int span);
        if ($urandom_range(0, 99) < 88) begin
            return key_pool[$urandom_range(0, span - 1)];
        end
        return $urandom();
    endfunction

    // Offer one command and hold it until the transfer edge; the caller drives
    // the next step in the same time slot, so start stays high back to back.
    task automatic send_item(lfu_pkg::t_req r);
        int gap;
        if (idle_enable && $urandom_range(0, 99) < 18) begin
            // Mostly short gaps; now and then one that spans a whole put miss.
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, lfu_pkg::DEPTH + 8)
                                              : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        shadow.note_command(r);
        commands_sent++;
    endtask

    // Drop start and wait until every predicted result has come back.
    task automatic let_drain(int extra);
        start <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Write the capacity register only with the block idle.
    task automatic set_capacity_reg(logic [lfu_pkg::CAP_W-1:0] v);
        let_drain(lfu_pkg::DEPTH + 4);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        shadow.set_capacity(v);
        i_cfg_we <= 1'b0;
        capacity_writes++;
    endtask

    task automatic run_random(int n, int span);
        lfu_pkg::t_req r;
        repeat (n) begin
            r = make_req(($urandom_range(0, 99) < 55) ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET,
                         pick_key(span), $urandom());
            send_item(r);
        end
    endtask

    initial begin
        shadow = new();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = $urandom();
        end

        // Hold reset from time zero, then release it for good.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-cache miss, extreme keys and values, put hit with
        // old value returned, all at the reset capacity.
        send_item(make_req(lfu_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(make_req(lfu_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(make_req(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_req(lfu_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000));
        send_item(make_req(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h5A5A_A5A5));
        send_item(make_req(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000));

        // Shrink to two entries so the next put miss has to evict.
        set_capacity_reg(lfu_pkg::CAP_W'(2));
        send_item(make_req(lfu_pkg::OP_PUT, 32'h0000_1234, 32'h1111_2222));
        send_item(make_req(lfu_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000));

        // Fill all entries, then force a count-one eviction.
        set_capacity_reg(lfu_pkg::CAP_W'(lfu_pkg::DEPTH));
        for (int i = 0; i < lfu_pkg::DEPTH - 2; i++) begin
            send_item(make_req(lfu_pkg::OP_PUT, 32'h0000_0100 + i, $urandom()));
        end
        send_item(make_req(lfu_pkg::OP_PUT, 32'h0000_0200, 32'hDEAD_0001));

        // Zero capacity: puts must not insert or update, gets still count.
        set_capacity_reg(lfu_pkg::CAP_W'(0));
        send_item(make_req(lfu_pkg::OP_PUT, 32'h0000_0100, 32'hCAFE_0000));
        send_item(make_req(lfu_pkg::OP_PUT, 32'h0000_0300, 32'hCAFE_0001));
        send_item(make_req(lfu_pkg::OP_GET, 32'h0000_0100, 32'h0000_0000));

        // Capacity below occupancy: a put miss swaps exactly one entry.
        set_capacity_reg(lfu_pkg::CAP_W'(3));
        send_item(make_req(lfu_pkg::OP_PUT, 32'h0000_0400, 32'hBEEF_0000));

        // Random phases across several capacity settings.
        set_capacity_reg('1);
        run_random(100, 24);
        let_drain(1);
        run_random(100, 24);

        // Long stretch with no sender gaps.
        idle_enable = 1'b0;
        set_capacity_reg(lfu_pkg::CAP_W'(lfu_pkg::DEPTH));
        run_random(250, 20);
        idle_enable = 1'b1;

        set_capacity_reg(lfu_pkg::CAP_W'(5));
        run_random(150, 10);
        set_capacity_reg(lfu_pkg::CAP_W'(1));
        run_random(100, 4);
        set_capacity_reg(lfu_pkg::CAP_W'(0));
        run_random(80, 12);
        set_capacity_reg(lfu_pkg::CAP_W'(lfu_pkg::DEPTH));
        run_random(120, 30);
        set_capacity_reg(lfu_pkg::CAP_W'(3));
        run_random(100, 8);
        set_capacity_reg(lfu_pkg::CAP_W'(8));
        run_random(50, 16);

        // Wait out every open result plus a margin for stray strobes.
        let_drain(lfu_pkg::DEPTH + 8);

        $display("Sent %0d commands: %0d hits, %0d evictions, %0d capacity writes",
                 commands_sent, hits_seen, evictions_seen, capacity_writes);
        $display("Included zero capacity, capacity below occupancy and full-cache evictions");
        if (shadow.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ lfu_cache_lru_tiebreak_unit.f @@
rtl/lfu_pkg.sv
rtl/lfu_cell.sv
rtl/lfu_cache_lru_tiebreak_unit.sv
test/lfu_cache_lru_tiebreak_unit_test.sv
